// File: src/pr2d_pkg.sv
// ----------------------------------------------------------------------------
// pr2d_pkg
// Shared widths, constants, arctangent table and beat types of the 2D point
// rotator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pr2d_pkg;

  // number of pipelined micro-rotations
  localparam int CORDIC_STAGES = 16;

  // coordinate format, signed fixed point
  localparam int COORD_W    = 32;
  // cos and sin are Q4.30: two bits of headroom above Q2.30 for the micro-rotation swing
  localparam int TRIG_SHIFT = 30;
  localparam int TRIG_W     = 34;
  // residual angle, 2^32 units per turn
  localparam int Z_W        = 32;
  localparam int ANGLE_W    = 16;

  localparam int PROD_W = COORD_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - TRIG_SHIFT;

  // start vector, CORDIC gain compensation 0.607252935 in Q2.30
  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = TRIG_W'(652032874);

  // quarter turn in residual angle units
  localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(64'sd1073741824);

  // arctangent of 2^-i in units of 2^32 per turn
  function automatic logic signed [Z_W-1:0] atan_at(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2F9;
      15:      v = 32'h0000517C;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A2F;
      19:      v = 32'h00000517;
      20:      v = 32'h0000028B;
      21:      v = 32'h00000145;
      22:      v = 32'h000000A2;
      23:      v = 32'h00000051;
      24:      v = 32'h00000028;
      25:      v = 32'h00000014;
      26:      v = 32'h0000000A;
      27:      v = 32'h00000005;
      28:      v = 32'h00000002;
      29:      v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return Z_W'(signed'(v));
  endfunction

  // beat inside the rotation pipeline
  typedef struct packed {
    logic                      valid;
    logic                      flip;
    logic signed [TRIG_W-1:0]  cx;
    logic signed [TRIG_W-1:0]  sy;
    logic signed [Z_W-1:0]     z;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } rot_beat_t;

  // beat after the multipliers
  typedef struct packed {
    logic                     valid;
    logic                     flip;
    logic signed [PROD_W-1:0] xc;
    logic signed [PROD_W-1:0] ys;
    logic signed [PROD_W-1:0] xs;
    logic signed [PROD_W-1:0] yc;
  } prod_beat_t;

  // beat after the sums
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] ax;
    logic signed [SUM_W-1:0] ay;
  } sum_beat_t;

endpackage

`default_nettype wire

// File: src/pr2d_reduce.sv
// ----------------------------------------------------------------------------
// pr2d_reduce
// Input stage: folds the angle into the right half plane and seeds the
// CORDIC start vector.
// ----------------------------------------------------------------------------
`default_nettype none

module pr2d_reduce (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic [pr2d_pkg::ANGLE_W-1:0]       angle,
  input  wire logic signed [pr2d_pkg::COORD_W-1:0] x_in,
  input  wire logic signed [pr2d_pkg::COORD_W-1:0] y_in,
  output pr2d_pkg::rot_beat_t                     beat
);
  import pr2d_pkg::*;

  logic signed [ANGLE_W:0] a_full;
  logic signed [ANGLE_W:0] a_res;
  logic                    flip;
  rot_beat_t               beat_next;

  // signed angle, remove a half turn beyond a quarter turn
  always_comb begin
    a_full = $signed({angle[ANGLE_W-1], angle});
    flip   = 1'b0;
    a_res  = a_full;
    if (a_full > 17'sd16384) begin
      a_res = a_full - 17'sd32768;
      flip  = 1'b1;
    end else if (a_full < -17'sd16384) begin
      a_res = a_full + 17'sd32768;
      flip  = 1'b1;
    end
  end

  // seed vector and residual angle
  always_comb begin
    beat_next.valid = in_valid;
    beat_next.flip  = flip;
    beat_next.cx    = GAIN_Q30;
    beat_next.sy    = '0;
    beat_next.z     = $signed({a_res[ANGLE_W-1:0], {(Z_W-ANGLE_W){1'b0}}});
    beat_next.px    = x_in;
    beat_next.py    = y_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= '0;
    end else if (en) begin
      beat <= beat_next;
    end
  end

  // residual angle never exceeds a quarter turn
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    beat.valid |-> (beat.z <= Z_QUARTER && beat.z >= -Z_QUARTER))
    else $error("residual angle out of range");

endmodule

`default_nettype wire

// File: src/pr2d_cordic.sv
// ----------------------------------------------------------------------------
// pr2d_cordic
// Rotation-mode CORDIC, one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pr2d_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire pr2d_pkg::rot_beat_t in_beat,
  output pr2d_pkg::rot_beat_t      out_beat
);
  import pr2d_pkg::*;

  localparam logic signed [TRIG_W-1:0] TRIG_HI = TRIG_W'(64'sd2147483647);
  localparam logic signed [TRIG_W-1:0] TRIG_LO = TRIG_W'(-64'sd2147483648);

  rot_beat_t stg [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    rot_beat_t src;
    rot_beat_t nxt;

    if (i == 0) begin : g_first
      assign src = in_beat;
    end else begin : g_rest
      assign src = stg[i-1];
    end

    // micro-rotation toward zero residual angle
    always_comb begin
      nxt = src;
      if (!src.z[Z_W-1]) begin
        nxt.cx = src.cx - (src.sy >>> i);
        nxt.sy = src.sy + (src.cx >>> i);
        nxt.z  = src.z - atan_at(i);
      end else begin
        nxt.cx = src.cx + (src.sy >>> i);
        nxt.sy = src.sy - (src.cx >>> i);
        nxt.z  = src.z + atan_at(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[i] <= '0;
      end else if (en) begin
        stg[i] <= nxt;
      end
    end
  end

  assign out_beat = stg[CORDIC_STAGES-1];

  // finished cos and sin fit a 32-bit signed range
  trig_range: assert property (@(posedge clk) disable iff (rst)
    out_beat.valid |-> (out_beat.cx <= TRIG_HI && out_beat.cx >= TRIG_LO &&
                        out_beat.sy <= TRIG_HI && out_beat.sy >= TRIG_LO))
    else $error("cordic output exceeds range");

endmodule

`default_nettype wire

// File: src/pr2d_mult.sv
// ----------------------------------------------------------------------------
// pr2d_mult
// Products of the point with cos and sin, then the two exact sums with the
// half-turn sign correction.
// ----------------------------------------------------------------------------
`default_nettype none

module pr2d_mult (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire pr2d_pkg::rot_beat_t  in_beat,
  output pr2d_pkg::sum_beat_t       out_beat
);
  import pr2d_pkg::*;

  prod_beat_t prod;
  prod_beat_t prod_next;
  sum_beat_t  sum_next;
  logic signed [SUM_W-1:0] dx;
  logic signed [SUM_W-1:0] dy;

  // four products
  always_comb begin
    prod_next.valid = in_beat.valid;
    prod_next.flip  = in_beat.flip;
    prod_next.xc    = in_beat.px * in_beat.cx;
    prod_next.ys    = in_beat.py * in_beat.sy;
    prod_next.xs    = in_beat.px * in_beat.sy;
    prod_next.yc    = in_beat.py * in_beat.cx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod <= '0;
    end else if (en) begin
      prod <= prod_next;
    end
  end

  // sums, negated when a half turn was removed
  always_comb begin
    dx = SUM_W'(prod.xc) - SUM_W'(prod.ys);
    dy = SUM_W'(prod.xs) + SUM_W'(prod.yc);
    sum_next.valid = prod.valid;
    sum_next.ax    = prod.flip ? -dx : dx;
    sum_next.ay    = prod.flip ? -dy : dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat <= '0;
    end else if (en) begin
      out_beat <= sum_next;
    end
  end

endmodule

`default_nettype wire

// File: src/pr2d_round.sv
// ----------------------------------------------------------------------------
// pr2d_round
// Rounds the Q30-scaled sums back to the coordinate format, saturates, and
// holds the result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pr2d_round (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire pr2d_pkg::sum_beat_t                  in_beat,
  output logic                                     out_valid,
  output logic signed [pr2d_pkg::COORD_W-1:0]      x_out,
  output logic signed [pr2d_pkg::COORD_W-1:0]      y_out
);
  import pr2d_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (TRIG_SHIFT - 1);
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-64'sd2147483648);

  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [SUM_W-1:0] acc
  );
    logic signed [SUM_W-1:0] biased;
    logic signed [RND_W-1:0] r;
    biased = acc + ROUND_HALF;
    r      = $signed(biased[SUM_W-1:TRIG_SHIFT]);
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return $signed(r[COORD_W-1:0]);
  endfunction

  logic signed [COORD_W-1:0] x_next;
  logic signed [COORD_W-1:0] y_next;

  // round half up and clamp
  always_comb begin
    x_next = round_sat(in_beat.ax);
    y_next = round_sat(in_beat.ay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
    end
  end

  // a frozen pipeline keeps the result beat unchanged
  hold_out: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(out_valid) && $stable(x_out) && $stable(y_out)))
    else $error("output changed while pipeline held");

endmodule

`default_nettype wire

// File: src/point_rotator_2d_unit.sv
// ----------------------------------------------------------------------------
// point_rotator_2d_unit
// Rotates a signed Q24.8 point about the origin by a 16-bit binary angle.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns x*cos - y*sin, x*sin + y*cos, rounded
// half up and saturated to 32 bits. The registers in order are angle folding,
// one register per CORDIC micro-rotation, the multiplier stage, the sum stage
// and the rounding/output register. The whole pipeline moves on one enable;
// it freezes only while a result beat sits in the output register with
// out_stall high, so in_stall follows out_stall in that cycle; with
// out_stall low it takes one beat per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotator_2d_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [pr2d_pkg::ANGLE_W-1:0]         angle,
  input  wire logic signed [pr2d_pkg::COORD_W-1:0]  x_in,
  input  wire logic signed [pr2d_pkg::COORD_W-1:0]  y_in,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [pr2d_pkg::COORD_W-1:0]       x_out,
  output logic signed [pr2d_pkg::COORD_W-1:0]       y_out
);
  import pr2d_pkg::*;

  logic      en;
  rot_beat_t seed_beat;
  rot_beat_t trig_beat;
  sum_beat_t sum_beat;

  // advance unless the output beat is waiting
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  pr2d_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .angle    (angle),
    .x_in     (x_in),
    .y_in     (y_in),
    .beat     (seed_beat)
  );

  pr2d_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_beat  (seed_beat),
    .out_beat (trig_beat)
  );

  pr2d_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_beat  (trig_beat),
    .out_beat (sum_beat)
  );

  pr2d_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_beat   (sum_beat),
    .out_valid (out_valid),
    .x_out     (x_out),
    .y_out     (y_out)
  );

  // input is held back only by a waiting output beat
  stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
